@@ rtl/fpp_pkg.sv @@
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types, sizes and the arctangent table of the fisheye pixel projection.
// ----------------------------------------------------------------------------
package fpp_pkg;

   // coefficient table
   localparam int MAX_TERMS   = 16;
   localparam int TERM_W      = $clog2(MAX_TERMS);
   localparam int CNT_W       = $clog2(MAX_TERMS + 1);
   localparam int HORNER_STEPS = MAX_TERMS - 1;

   // square root: two result bits per stage
   localparam int SQRT_STAGES = 16;

   // angle and division: two iterations per stage
   localparam int CORDIC_ITERS = 25;
   localparam int GEO_STAGES   = (CORDIC_ITERS + 1) / 2;
   localparam int QUOT_W       = CORDIC_ITERS;

   // internal widths
   localparam int CX_W   = 56;
   localparam int DIV_W  = 57;
   localparam int ANG_W  = 27;
   localparam int UNIT_W = QUOT_W + 1;
   localparam int RHO_W  = 36;
   localparam int PH_W   = 18 + ANG_W;
   localparam int PL_W   = 19 + ANG_W;
   localparam int QH_W   = 18 + UNIT_W;
   localparam int QL_W   = 19 + UNIT_W;

   // item kinds
   localparam logic REQ_COEF = 1'b0;
   localparam logic REQ_RAY  = 1'b1;

   // register indexes
   typedef enum logic [2:0] {
      CSR_CENTER_ROW = 3'd0,
      CSR_CENTER_COL = 3'd1,
      CSR_AFFINE_C   = 3'd2,
      CSR_AFFINE_D   = 3'd3,
      CSR_AFFINE_E   = 3'd4,
      CSR_POLY_TERMS = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic               req_type;
      logic [3:0]         coef_index;
      logic signed [31:0] coef_value;
      logic signed [31:0] ray_x;
      logic signed [31:0] ray_y;
      logic signed [31:0] ray_z;
   } fpp_req_type;

   typedef struct packed {
      logic signed [31:0] pixel_row;
      logic signed [31:0] pixel_col;
      logic               on_axis;
   } fpp_rsp_type;

   // angle, unit vector and pass-through write of one item
   typedef struct packed {
      logic                     is_ray;
      logic [3:0]               wr_idx;
      logic signed [31:0]       wr_val;
      logic                     on_axis;
      logic signed [ANG_W-1:0]  theta;
      logic signed [UNIT_W-1:0] ux;
      logic signed [UNIT_W-1:0] uy;
   } fpp_geo_type;

   // atan(2^-i) in Q.24, rounded
   function automatic logic [23:0] atan_q24(input int i);
      logic [23:0] v;
      case (i)
         0:  v = 24'd13176795;
         1:  v = 24'd7778716;
         2:  v = 24'd4110060;
         3:  v = 24'd2086331;
         4:  v = 24'd1047214;
         5:  v = 24'd524117;
         6:  v = 24'd262123;
         7:  v = 24'd131069;
         default: v = (i < 24) ? (24'd65536 >> (i - 8)) : 24'd1;
      endcase
      return v;
   endfunction

   // term count clamped to 1..MAX_TERMS
   function automatic logic [CNT_W-1:0] clamp_terms(input logic [4:0] t);
      logic [CNT_W-1:0] n;
      if (t == 5'd0) begin
         n = CNT_W'(1);
      end else if (int'(t) > MAX_TERMS) begin
         n = CNT_W'(MAX_TERMS);
      end else begin
         n = CNT_W'(t);
      end
      return n;
   endfunction

endpackage

@@ rtl/fpp_geom.sv @@
// ----------------------------------------------------------------------------
// fpp_geom
// In-plane norm by digit square root, incidence angle by vectoring rotation,
// and the unit components x/norm, y/norm by restoring division.
// ----------------------------------------------------------------------------
module fpp_geom import fpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_vld,
   input  fpp_req_type in_data,
   output logic        out_vld,
   output fpp_geo_type out_data
);

   localparam int NSQ = SQRT_STAGES + 2;

   typedef struct packed {
      logic               is_ray;
      logic [3:0]         wr_idx;
      logic signed [31:0] wr_val;
      logic               sx;
      logic               sy;
      logic [31:0]        mx;
      logic [31:0]        my;
      logic signed [31:0] rz;
      logic [63:0]        xx;
      logic [63:0]        yy;
      logic [63:0]        sq_v;
      logic [35:0]        sq_rem;
      logic [31:0]        root;
   } sq_type;

   typedef struct packed {
      logic                    is_ray;
      logic [3:0]              wr_idx;
      logic signed [31:0]      wr_val;
      logic                    sx;
      logic                    sy;
      logic                    zero;
      logic [31:0]             nrm;
      logic signed [CX_W-1:0]  cx;
      logic signed [CX_W-1:0]  cy;
      logic signed [ANG_W-1:0] ang;
      logic [DIV_W-1:0]        rem_x;
      logic [DIV_W-1:0]        rem_y;
      logic [QUOT_W-1:0]       qx;
      logic [QUOT_W-1:0]       qy;
   } cd_type;

   // one square root digit
   function automatic sq_type sq_iter(input sq_type s);
      sq_type      o;
      logic [35:0] r;
      logic [35:0] t;
      o = s;
      r = {s.sq_rem[33:0], s.sq_v[63:62]};
      t = {2'b00, s.root, 2'b01};
      o.sq_v = {s.sq_v[61:0], 2'b00};
      if (r >= t) begin
         o.sq_rem = r - t;
         o.root   = {s.root[30:0], 1'b1};
      end else begin
         o.sq_rem = r;
         o.root   = {s.root[30:0], 1'b0};
      end
      return o;
   endfunction

   // start of rotation and division from the norm
   function automatic cd_type cd_init(input sq_type s);
      cd_type o;
      o.is_ray = s.is_ray;
      o.wr_idx = s.wr_idx;
      o.wr_val = s.wr_val;
      o.sx     = s.sx;
      o.sy     = s.sy;
      o.zero   = (s.root == 32'd0);
      o.nrm    = s.root;
      o.cx     = $signed({4'b0000, s.root, 20'd0});
      o.cy     = $signed({{(CX_W - 52){s.rz[31]}}, s.rz, 20'd0});
      o.ang    = '0;
      o.rem_x  = DIV_W'({s.mx, 24'd0}) + DIV_W'(s.root[31:1]);
      o.rem_y  = DIV_W'({s.my, 24'd0}) + DIV_W'(s.root[31:1]);
      o.qx     = '0;
      o.qy     = '0;
      return o;
   endfunction

   // one rotation step and one quotient bit of each division
   function automatic cd_type cd_iter(input cd_type s, input int i);
      cd_type                 o;
      logic signed [CX_W-1:0] dx;
      logic signed [CX_W-1:0] dy;
      logic [DIV_W-1:0]       dd;
      o  = s;
      dx = s.cy >>> i;
      dy = s.cx >>> i;
      if (!s.cy[CX_W-1]) begin
         o.cx  = s.cx + dx;
         o.cy  = s.cy - dy;
         o.ang = s.ang + $signed(ANG_W'(atan_q24(i)));
      end else begin
         o.cx  = s.cx - dx;
         o.cy  = s.cy + dy;
         o.ang = s.ang - $signed(ANG_W'(atan_q24(i)));
      end
      dd = DIV_W'(s.nrm) << (QUOT_W - 1 - i);
      if (s.rem_x >= dd) begin
         o.rem_x = s.rem_x - dd;
         o.qx[QUOT_W - 1 - i] = 1'b1;
      end
      if (s.rem_y >= dd) begin
         o.rem_y = s.rem_y - dd;
         o.qy[QUOT_W - 1 - i] = 1'b1;
      end
      return o;
   endfunction

   sq_type           sq_in  [NSQ];
   sq_type           sq_ff  [NSQ];
   logic [NSQ-1:0]   sq_vld_ff;
   cd_type           cd_in  [GEO_STAGES];
   cd_type           cd_ff  [GEO_STAGES];
   logic [GEO_STAGES-1:0] cd_vld_ff;

   // magnitudes and squares
   always_comb begin
      sq_in[0]        = '0;
      sq_in[0].is_ray = in_data.req_type;
      sq_in[0].wr_idx = in_data.coef_index;
      sq_in[0].wr_val = in_data.coef_value;
      sq_in[0].sx     = in_data.ray_x[31];
      sq_in[0].sy     = in_data.ray_y[31];
      sq_in[0].mx     = in_data.ray_x[31] ? 32'(-in_data.ray_x) : 32'(in_data.ray_x);
      sq_in[0].my     = in_data.ray_y[31] ? 32'(-in_data.ray_y) : 32'(in_data.ray_y);
      sq_in[0].rz     = in_data.ray_z;
      sq_in[0].xx     = sq_in[0].mx * sq_in[0].mx;
      sq_in[0].yy     = sq_in[0].my * sq_in[0].my;
   end

   genvar g;
   generate
      for (g = 1; g < NSQ; g++) begin : g_sq
         if (g == 1) begin : g_sum
            // sum of squares seeds the root
            always_comb begin
               sq_in[g]        = sq_ff[g-1];
               sq_in[g].sq_v   = sq_ff[g-1].xx + sq_ff[g-1].yy;
               sq_in[g].sq_rem = '0;
               sq_in[g].root   = '0;
            end
         end else begin : g_dig
            assign sq_in[g] = sq_iter(sq_iter(sq_ff[g-1]));
         end
      end

      for (g = 0; g < NSQ; g++) begin : g_sq_reg
         always_ff @(posedge clock) begin
            if (reset) begin
               sq_vld_ff[g] <= 1'b0;
            end else if (adv) begin
               sq_vld_ff[g] <= (g == 0) ? in_vld : sq_vld_ff[(g == 0) ? 0 : g-1];
            end
            if (adv) begin
               sq_ff[g] <= sq_in[g];
            end
         end
      end

      for (g = 0; g < GEO_STAGES; g++) begin : g_cd
         // two rotation steps, last stage may hold one
         if (g == 0) begin : g_first
            assign cd_in[g] = cd_iter(cd_iter(cd_init(sq_ff[NSQ-1]), 0), 1);
         end else if (2*g + 1 < CORDIC_ITERS) begin : g_two
            assign cd_in[g] = cd_iter(cd_iter(cd_ff[g-1], 2*g), 2*g + 1);
         end else begin : g_one
            assign cd_in[g] = cd_iter(cd_ff[g-1], 2*g);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               cd_vld_ff[g] <= 1'b0;
            end else if (adv) begin
               cd_vld_ff[g] <= (g == 0) ? sq_vld_ff[NSQ-1] : cd_vld_ff[(g == 0) ? 0 : g-1];
            end
            if (adv) begin
               cd_ff[g] <= cd_in[g];
            end
         end
      end
   endgenerate

   // signed unit components and angle
   always_comb begin
      out_vld          = cd_vld_ff[GEO_STAGES-1];
      out_data.is_ray  = cd_ff[GEO_STAGES-1].is_ray;
      out_data.wr_idx  = cd_ff[GEO_STAGES-1].wr_idx;
      out_data.wr_val  = cd_ff[GEO_STAGES-1].wr_val;
      out_data.on_axis = cd_ff[GEO_STAGES-1].zero;
      out_data.theta   = cd_ff[GEO_STAGES-1].ang;
      out_data.ux      = cd_ff[GEO_STAGES-1].sx ?
                         -$signed({1'b0, cd_ff[GEO_STAGES-1].qx}) :
                          $signed({1'b0, cd_ff[GEO_STAGES-1].qx});
      out_data.uy      = cd_ff[GEO_STAGES-1].sy ?
                         -$signed({1'b0, cd_ff[GEO_STAGES-1].qy}) :
                          $signed({1'b0, cd_ff[GEO_STAGES-1].qy});
   end

endmodule

@@ rtl/fisheye_ray_to_pixel_projection_unit.sv @@
// ----------------------------------------------------------------------------
// fisheye_ray_to_pixel_projection_unit
// Projects camera rays to fisheye pixel coordinates through a radial
// polynomial of the incidence angle and a 2x2 affine plus image center.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry items. A coefficient item stores one
//   polynomial coefficient and gives no result; a ray item gives one result
//   on rsp_valid/rsp_stall/rsp_data, in order.
//   csr_valid/csr_ready/csr_index/csr_wdata write the center, affine and
//   term count registers; csr_ready is always high. Write them while idle.
// Timing:
//   66 register stages: 2 for the squares, 16 for the square root (two
//   digits a stage), 13 for angle rotation and the two divisions (two steps
//   a stage), 1 coefficient snapshot, 30 for the Horner chain (multiply and
//   round per term), 2 for scaling and 2 for the affine map.
//   One item is accepted per cycle when the output is not stalled.
// Reset clears the valid bits and the coefficient table and sets the configuration registers to their defaults.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fisheye_ray_to_pixel_projection_unit import fpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fpp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fpp_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int NHS = 2 * HORNER_STEPS;

   typedef struct packed {
      logic                          on_axis;
      logic [CNT_W-1:0]              n;
      logic signed [ANG_W-1:0]       theta;
      logic signed [UNIT_W-1:0]      ux;
      logic signed [UNIT_W-1:0]      uy;
      logic [MAX_TERMS-1:0][31:0]    coef;
      logic signed [RHO_W-1:0]       rho;
      logic signed [PH_W-1:0]        ph;
      logic signed [PL_W-1:0]        pl;
   } hn_type;

   typedef struct packed {
      logic                    on_axis;
      logic signed [QH_W-1:0]  xh;
      logic signed [QL_W-1:0]  xl;
      logic signed [QH_W-1:0]  yh;
      logic signed [QL_W-1:0]  yl;
   } sc_type;

   typedef struct packed {
      logic               on_axis;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } xy_type;

   typedef struct packed {
      logic               on_axis;
      logic signed [31:0] y;
      logic signed [63:0] xc;
      logic signed [63:0] yd;
      logic signed [63:0] xe;
   } af_type;

   // multiply half of one Horner step
   function automatic hn_type hn_mul(input hn_type s);
      hn_type o;
      o    = s;
      o.ph = $signed(s.rho[RHO_W-1:18]) * s.theta;
      o.pl = $signed({1'b0, s.rho[17:0]}) * s.theta;
      return o;
   endfunction

   // round, add coefficient k-1, saturate; idle unless k is below the term count
   function automatic hn_type hn_add(input hn_type s, input int k);
      hn_type             o;
      logic signed [63:0] p;
      logic signed [40:0] r;
      logic signed [40:0] c;
      o = s;
      p = ($signed({{(64 - PH_W){s.ph[PH_W-1]}}, s.ph}) <<< 18) +
          $signed({{(64 - PL_W){s.pl[PL_W-1]}}, s.pl}) + 64'sd8388608;
      c = $signed({{9{s.coef[k-1][31]}}, s.coef[k-1]});
      r = $signed(p[63:24]) + c;
      if (int'(s.n) > k) begin
         if (r > 41'sd34359738367) begin
            o.rho = 36'sh7FFFFFFFF;
         end else if (r < -41'sd34359738368) begin
            o.rho = 36'sh800000000;
         end else begin
            o.rho = r[RHO_W-1:0];
         end
      end
      return o;
   endfunction

   // round a scaled product to Q16.16 with symmetric saturation
   function automatic logic signed [31:0] xy_round(input logic signed [QH_W-1:0] h,
                                                   input logic signed [QL_W-1:0] l);
      logic signed [63:0] p;
      logic signed [35:0] v;
      logic signed [31:0] o;
      p = ($signed({{(64 - QH_W){h[QH_W-1]}}, h}) <<< 18) +
          $signed({{(64 - QL_W){l[QL_W-1]}}, l}) + 64'sd134217728;
      v = p[63:28];
      if (v > 36'sd2147483647) begin
         o = 32'sh7FFFFFFF;
      end else if (v < -36'sd2147483647) begin
         o = 32'sh80000001;
      end else begin
         o = v[31:0];
      end
      return o;
   endfunction

   // round a Q21.44 sum to Q16.16, add the center, saturate
   function automatic logic signed [31:0] px_round(input logic signed [64:0] s,
                                                   input logic signed [31:0] ctr);
      logic signed [64:0] p;
      logic signed [37:0] t;
      logic signed [31:0] o;
      p = s + 65'sd134217728;
      t = $signed({p[64], p[64:28]}) + $signed({{6{ctr[31]}}, ctr});
      if (t > 38'sd2147483647) begin
         o = 32'sh7FFFFFFF;
      end else if (t < -38'sd2147483648) begin
         o = 32'sh80000000;
      end else begin
         o = t[31:0];
      end
      return o;
   endfunction

   logic                       adv;
   logic                       geo_vld;
   fpp_geo_type                geo;
   logic signed [31:0]         center_row_ff;
   logic signed [31:0]         center_col_ff;
   logic signed [31:0]         affine_c_ff;
   logic signed [31:0]         affine_d_ff;
   logic signed [31:0]         affine_e_ff;
   logic [4:0]                 poly_terms_ff;
   logic [MAX_TERMS-1:0][31:0] coef_ff;
   hn_type                     h0_in;
   hn_type                     h0_ff;
   logic                       h0_vld_ff;
   hn_type                     hs_in [NHS];
   hn_type                     hs_ff [NHS];
   logic [NHS-1:0]             hs_vld_ff;
   sc_type                     sc_in;
   sc_type                     sc_ff;
   logic                       sc_vld_ff;
   xy_type                     xy_in;
   xy_type                     xy_ff;
   logic                       xy_vld_ff;
   af_type                     af_in;
   af_type                     af_ff;
   logic                       af_vld_ff;
   fpp_rsp_type                rsp_in;
   fpp_rsp_type                rsp_ff;
   logic                       rsp_vld_ff;

   // whole pipeline moves unless a result waits on a stalled receiver
   assign adv       = !(rsp_vld_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_row_ff <= '0;
         center_col_ff <= '0;
         affine_c_ff   <= 32'sd268435456;
         affine_d_ff   <= '0;
         affine_e_ff   <= '0;
         poly_terms_ff <= 5'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CENTER_ROW: center_row_ff <= csr_wdata;
            CSR_CENTER_COL: center_col_ff <= csr_wdata;
            CSR_AFFINE_C:   affine_c_ff   <= csr_wdata;
            CSR_AFFINE_D:   affine_d_ff   <= csr_wdata;
            CSR_AFFINE_E:   affine_e_ff   <= csr_wdata;
            CSR_POLY_TERMS: poly_terms_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   fpp_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req_valid),
      .in_data  (req_data),
      .out_vld  (geo_vld),
      .out_data (geo)
   );

   // coefficient writes land here, in item order with the rays
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (adv && geo_vld && geo.is_ray == REQ_COEF &&
                   int'(geo.wr_idx) < MAX_TERMS) begin
         coef_ff[TERM_W'(geo.wr_idx)] <= geo.wr_val;
      end
   end

   // snapshot of the table and the highest coefficient
   always_comb begin
      h0_in         = '0;
      h0_in.on_axis = geo.on_axis;
      h0_in.n       = clamp_terms(poly_terms_ff);
      h0_in.theta   = geo.theta;
      h0_in.ux      = geo.ux;
      h0_in.uy      = geo.uy;
      h0_in.coef    = coef_ff;
      h0_in.rho     = $signed({{(RHO_W - 32){coef_ff[TERM_W'(h0_in.n - CNT_W'(1))][31]}},
                               coef_ff[TERM_W'(h0_in.n - CNT_W'(1))]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h0_vld_ff <= 1'b0;
      end else if (adv) begin
         h0_vld_ff <= geo_vld && geo.is_ray == REQ_RAY;
      end
      if (adv) begin
         h0_ff <= h0_in;
      end
   end

   // Horner chain: even stages multiply, odd stages add term k-1
   genvar g;
   generate
      for (g = 0; g < NHS; g++) begin : g_hn
         if (g == 0) begin : g_first
            assign hs_in[g] = hn_mul(h0_ff);
         end else if (g % 2 == 0) begin : g_mul
            assign hs_in[g] = hn_mul(hs_ff[g-1]);
         end else begin : g_add
            assign hs_in[g] = hn_add(hs_ff[g-1], MAX_TERMS - 1 - g / 2);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               hs_vld_ff[g] <= 1'b0;
            end else if (adv) begin
               hs_vld_ff[g] <= (g == 0) ? h0_vld_ff : hs_vld_ff[(g == 0) ? 0 : g-1];
            end
            if (adv) begin
               hs_ff[g] <= hs_in[g];
            end
         end
      end
   endgenerate

   // unit components times rho, split in halves
   always_comb begin
      sc_in.on_axis = hs_ff[NHS-1].on_axis;
      sc_in.xh = $signed(hs_ff[NHS-1].rho[RHO_W-1:18]) * hs_ff[NHS-1].ux;
      sc_in.xl = $signed({1'b0, hs_ff[NHS-1].rho[17:0]}) * hs_ff[NHS-1].ux;
      sc_in.yh = $signed(hs_ff[NHS-1].rho[RHO_W-1:18]) * hs_ff[NHS-1].uy;
      sc_in.yl = $signed({1'b0, hs_ff[NHS-1].rho[17:0]}) * hs_ff[NHS-1].uy;
   end

   // rounded image-plane x and y
   always_comb begin
      xy_in.on_axis = sc_ff.on_axis;
      xy_in.x       = xy_round(sc_ff.xh, sc_ff.xl);
      xy_in.y       = xy_round(sc_ff.yh, sc_ff.yl);
   end

   // affine products
   always_comb begin
      af_in.on_axis = xy_ff.on_axis;
      af_in.y       = xy_ff.y;
      af_in.xc      = xy_ff.x * affine_c_ff;
      af_in.yd      = xy_ff.y * affine_d_ff;
      af_in.xe      = xy_ff.x * affine_e_ff;
   end

   // final sums with center, or the center alone on the axis
   always_comb begin
      rsp_in.on_axis = af_ff.on_axis;
      if (af_ff.on_axis) begin
         rsp_in.pixel_row = center_row_ff;
         rsp_in.pixel_col = center_col_ff;
      end else begin
         rsp_in.pixel_row = px_round($signed({af_ff.xc[63], af_ff.xc}) +
                                     $signed({af_ff.yd[63], af_ff.yd}), center_row_ff);
         rsp_in.pixel_col = px_round($signed({af_ff.xe[63], af_ff.xe}) +
                                     $signed({{5{af_ff.y[31]}}, af_ff.y, 28'd0}),
                                     center_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_vld_ff  <= 1'b0;
         xy_vld_ff  <= 1'b0;
         af_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         sc_vld_ff  <= hs_vld_ff[NHS-1];
         xy_vld_ff  <= sc_vld_ff;
         af_vld_ff  <= xy_vld_ff;
         rsp_vld_ff <= af_vld_ff;
      end
      if (adv) begin
         sc_ff  <= sc_in;
         xy_ff  <= xy_in;
         af_ff  <= af_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule
